// ===== rtl/bme_pkg.sv =====
// Shared types and constants for the bicycle model Euler step block.
// Used by bme_cordic and bicycle_model_euler_step.
package bme_pkg;

	localparam int CORDIC_N   = 30;
	localparam int ANG_SHIFT  = 14;  // Q.16 -> Q.30

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [40:0] PI_Q30      = 41'sd3373259426;
	localparam logic signed [40:0] HALF_PI_Q30 = 41'sd1686629713;
	localparam logic        [39:0] TWO_PI_Q30  = 40'd6746518852;
	// pi plus 22 turns: keeps the heading argument positive for the reduction
	localparam logic signed [40:0] RED_OFF     = 41'sd151796674170;

	localparam logic [29:0] ATAN_TAB [CORDIC_N] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] hd;
		logic signed [17:0] v;
		logic               neg;
	} car_t;

endpackage

// ===== rtl/bicycle_model_euler_step.sv =====
// Kinematic bicycle model, one forward Euler step per request.
// One request per cycle, except while the pipeline is frozen (see below).
// The whole pipeline advances together; it freezes while the output is stalled.
// It holds two 30-stage CORDICs and a 31-stage restoring divider for tan(steer).
// Reset clears all stage valid bits and sets step_time to 0.25.
module bicycle_model_euler_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,   // step_time
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,       // pos_x, pos_y, heading, speed, steer_angle, pad
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [71:0]   m_tdata        // next_x, next_y, next_heading
);

	localparam int NST = 73;
	localparam logic signed [63:0] RND = 64'sd536870912;

	logic [15:0] step_time_q;
	logic [NST-1:0] vld_q;
	logic adv;
	logic signed [16:0] tau;

	assign adv      = !vld_q[NST-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NST-1];
	assign tau      = $signed({1'b0, step_time_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 16'd16384;
			vld_q       <= '0;
		end else begin
			if (cfg_wr_en) step_time_q <= cfg_wr_data;
			if (adv) vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	function automatic logic [39:0] red_step(input logic [39:0] r, input int k);
		logic [39:0] m;
		m = bme_pkg::TWO_PI_Q30 << k;
		return (r >= m) ? r - m : r;
	endfunction

	function automatic logic [23:0] sat24(input logic signed [39:0] v);
		if (v > 40'sd8388607) return 24'h7FFFFF;
		if (v < -40'sd8388608) return 24'h800000;
		return v[23:0];
	endfunction

	// front: capture, heading range reduction, steering clamp, fold
	bme_pkg::car_t car_s1, car_s2, car_s3, car_s4, car_s5;
	logic signed [17:0] d_s1, d_s2, d_s3, d_s4;
	logic [39:0] r_s1, r_s2, r_s3, r_s4;
	logic signed [33:0] zh_s5, zd_s5;
	logic signed [40:0] a_red;
	logic signed [17:0] d_cl;
	logic signed [33:0] zh_fold;
	logic neg_fold;
	bme_pkg::car_t car_in;

	assign car_in = '{px: s_tdata[23:0], py: s_tdata[47:24], hd: s_tdata[71:48],
		v: s_tdata[89:72], neg: 1'b0};
	assign a_red = $signed({1'b0, r_s4}) - bme_pkg::PI_Q30;
	assign d_cl  = (d_s4 > 18'sd65536) ? 18'sd65536 :
		(d_s4 < -18'sd65536) ? -18'sd65536 : d_s4;

	// fold into [-pi/2, pi/2]; results get negated downstream when folded
	always_comb begin
		if (a_red > bme_pkg::HALF_PI_Q30) begin
			zh_fold  = 34'(a_red - bme_pkg::PI_Q30);
			neg_fold = 1'b1;
		end else if (a_red < -bme_pkg::HALF_PI_Q30) begin
			zh_fold  = 34'(a_red + bme_pkg::PI_Q30);
			neg_fold = 1'b1;
		end else begin
			zh_fold  = 34'(a_red);
			neg_fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s1 <= car_in;
			d_s1   <= s_tdata[107:90];
			r_s1   <= 40'((41'($signed(s_tdata[71:48])) <<< bme_pkg::ANG_SHIFT)
				+ bme_pkg::RED_OFF);
			car_s2 <= car_s1; d_s2 <= d_s1; r_s2 <= red_step(red_step(r_s1, 5), 4);
			car_s3 <= car_s2; d_s3 <= d_s2; r_s3 <= red_step(red_step(r_s2, 3), 2);
			car_s4 <= car_s3; d_s4 <= d_s3; r_s4 <= red_step(red_step(r_s3, 1), 0);
			car_s5 <= '{px: car_s4.px, py: car_s4.py, hd: car_s4.hd, v: car_s4.v,
				neg: neg_fold};
			zh_s5  <= zh_fold;
			zd_s5  <= 34'(d_cl) <<< bme_pkg::ANG_SHIFT;
		end
	end

	// sine/cosine of heading and steering
	logic signed [32:0] ch_c, sh_c, cd_c, sd_c;
	bme_pkg::car_t car_c [bme_pkg::CORDIC_N];

	bme_cordic u_cordic_h (.clk(clk), .en(adv), .z_in(zh_s5), .cos_out(ch_c), .sin_out(sh_c));
	bme_cordic u_cordic_d (.clk(clk), .en(adv), .z_in(zd_s5), .cos_out(cd_c), .sin_out(sd_c));

	for (genvar i = 0; i < bme_pkg::CORDIC_N; i++) begin : g_cdly
		always_ff @(posedge clk) begin
			if (adv) car_c[i] <= (i == 0) ? car_s5 : car_c[(i == 0) ? 0 : i-1];
		end
	end

	// divider setup
	bme_pkg::car_t car_s36;
	logic signed [32:0] ch_s36, sh_s36;
	logic [31:0] cd_s36;
	logic [30:0] sdabs_s36;
	logic sneg_s36;
	logic signed [32:0] sd_abs;

	assign sd_abs = sd_c[32] ? -sd_c : sd_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s36   <= car_c[bme_pkg::CORDIC_N-1];
			ch_s36    <= car_c[bme_pkg::CORDIC_N-1].neg ? -ch_c : ch_c;
			sh_s36    <= car_c[bme_pkg::CORDIC_N-1].neg ? -sh_c : sh_c;
			cd_s36    <= (cd_c < 33'sd1) ? 32'd1 : cd_c[31:0];
			sdabs_s36 <= sd_abs[30:0];
			sneg_s36  <= sd_c[32];
		end
	end

	// tan(steer) = sin * 2^30 / cos, one quotient bit per stage
	localparam int DN = 31;
	logic [32:0] rem_d [DN];
	logic [30:0] quo_d [DN];
	logic [31:0] cd_d [DN];
	logic signed [32:0] ch_d [DN];
	logic signed [32:0] sh_d [DN];
	logic sneg_d [DN];
	bme_pkg::car_t car_d [DN];

	for (genvar j = 0; j < DN; j++) begin : g_div
		logic [32:0] rin;
		logic [30:0] qin;
		logic [31:0] dv;  // divisor traveling alongside this stage's operand
		logic ge;
		if (j == 0) begin : g_first
			assign rin = {2'b0, sdabs_s36};
			assign qin = '0;
			assign dv  = cd_s36;
			always_ff @(posedge clk) begin
				if (adv) begin
					cd_d[j] <= cd_s36; ch_d[j] <= ch_s36; sh_d[j] <= sh_s36;
					sneg_d[j] <= sneg_s36; car_d[j] <= car_s36;
				end
			end
		end else begin : g_next
			assign rin = {rem_d[j-1][31:0], 1'b0};
			assign qin = quo_d[j-1];
			assign dv  = cd_d[j-1];
			always_ff @(posedge clk) begin
				if (adv) begin
					cd_d[j] <= cd_d[j-1]; ch_d[j] <= ch_d[j-1]; sh_d[j] <= sh_d[j-1];
					sneg_d[j] <= sneg_d[j-1]; car_d[j] <= car_d[j-1];
				end
			end
		end
		assign ge = rin >= {1'b0, dv};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_d[j] <= ge ? rin - {1'b0, dv} : rin;
				quo_d[j] <= {qin[29:0], ge};
			end
		end
	end

	// back end: direction terms, increments, saturation
	bme_pkg::car_t car_s68, car_s69, car_s70, car_s71, car_s72;
	logic signed [31:0] t_s68;
	logic signed [32:0] ch_s68, sh_s68, ch_s69, sh_s69;
	logic signed [64:0] pxs_s69, pys_s69;
	logic signed [49:0] pvt_s69;
	logic signed [33:0] cx_s70, cy_s70;
	logic signed [50:0] mh_s70;
	logic signed [51:0] pvx_s71, pvy_s71;
	logic [23:0] nh_s71, nh_s72, nx_s73, ny_s73, nh_s73;
	logic signed [52:0] mx_s72, my_s72;
	logic [30:0] qf;

	assign qf = quo_d[DN-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s68 <= car_d[DN-1];
			ch_s68  <= ch_d[DN-1];
			sh_s68  <= sh_d[DN-1];
			t_s68   <= sneg_d[DN-1] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

			car_s69 <= car_s68; ch_s69 <= ch_s68; sh_s69 <= sh_s68;
			pxs_s69 <= t_s68 * sh_s68;
			pys_s69 <= t_s68 * ch_s68;
			pvt_s69 <= car_s68.v * t_s68;

			car_s70 <= car_s69;
			cx_s70  <= 34'(ch_s69) - 34'(pxs_s69 >>> 31);
			cy_s70  <= 34'(sh_s69) + 34'(pys_s69 >>> 31);
			mh_s70  <= $signed(34'(pvt_s69 >>> 16)) * tau;

			car_s71 <= car_s70;
			pvx_s71 <= car_s70.v * cx_s70;
			pvy_s71 <= car_s70.v * cy_s70;
			nh_s71  <= sat24(40'(car_s70.hd) + 40'((64'(mh_s70) + RND) >>> 30));

			car_s72 <= car_s71; nh_s72 <= nh_s71;
			mx_s72  <= $signed(36'(pvx_s71 >>> 16)) * tau;
			my_s72  <= $signed(36'(pvy_s71 >>> 16)) * tau;

			nx_s73  <= sat24(40'(car_s72.px) + 40'((64'(mx_s72) + RND) >>> 30));
			ny_s73  <= sat24(40'(car_s72.py) + 40'((64'(my_s72) + RND) >>> 30));
			nh_s73  <= nh_s72;
		end
	end

	assign m_tdata = {nh_s73, ny_s73, nx_s73};

endmodule

// ===== rtl/bme_cordic.sv =====
// Pipelined rotation CORDIC, one iteration per register stage, Q.30 angles.
// Uses bme_pkg for the arctangent table and gain.
module bme_cordic (
	input  logic                clk,
	input  logic                en,
	input  logic signed [33:0]  z_in,
	output logic signed [32:0]  cos_out,
	output logic signed [32:0]  sin_out
);

	logic signed [32:0] x_s [bme_pkg::CORDIC_N];
	logic signed [32:0] y_s [bme_pkg::CORDIC_N];
	logic signed [33:0] z_s [bme_pkg::CORDIC_N];

	for (genvar i = 0; i < bme_pkg::CORDIC_N; i++) begin : g_it
		logic signed [32:0] xi, yi;
		logic signed [33:0] zi, at;
		if (i == 0) begin : g_first
			assign xi = bme_pkg::CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end
		assign at = $signed({4'b0, bme_pkg::ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[33]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - at;
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + at;
				end
			end
		end
	end

	assign cos_out = x_s[bme_pkg::CORDIC_N-1];
	assign sin_out = y_s[bme_pkg::CORDIC_N-1];

endmodule
